// File: rtl/cfm_pkg.sv
package cfm_pkg;

  // Fixed field widths of the block's ports.
  localparam int unsigned RATE_BITS    = 24;
  localparam int unsigned RESULT_BITS  = 32;
  localparam int unsigned FRAC_BITS    = 8;
  localparam logic [RATE_BITS-1:0] RATE_RESET = 24'd15625;

  // The divider works on one quotient bit per cycle.
  localparam int unsigned DIV_BITS     = 32;
  localparam int unsigned DIV_CNT_BITS = 5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_OUTPUT
  } cfm_state_e;

  // Request into the divider: start pulse and operands.
  typedef struct packed {
    logic                start;
    logic [DIV_BITS-1:0] dividend;
    logic [DIV_BITS-1:0] divisor;
  } cfm_div_req_t;

  // Status from the divider.
  typedef struct packed {
    logic                busy;
    logic [DIV_BITS-1:0] quotient;
  } cfm_div_sts_t;

endpackage

// File: rtl/cfm_timer.sv
module cfm_timer
  import cfm_pkg::*;
#(
  parameter int unsigned COUNTER_BITS  = 16,
  parameter int unsigned OVERFLOW_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   tick_i,
  input  logic                   edge_i,
  output logic [RESULT_BITS-1:0] period_o
);

  // Span width: room for overflow and counter plus a sign bit, at least 34 bits
  // so that the saturation check always has bits above the result.
  localparam int unsigned SPAN_RAW = OVERFLOW_BITS + COUNTER_BITS + 1;
  localparam int unsigned SPAN_W   = (SPAN_RAW > RESULT_BITS + 2) ? SPAN_RAW : RESULT_BITS + 2;

  logic [COUNTER_BITS-1:0]  timer_q, timer_d;
  logic [OVERFLOW_BITS-1:0] ovf_q, ovf_d, ovf_base;
  logic [COUNTER_BITS-1:0]  latest_q, latest_d;
  logic [SPAN_W-1:0]        span;

  // Period between the previous capture and the counter value of this tick.
  always_comb begin
    span = (SPAN_W'(ovf_q) << COUNTER_BITS) + SPAN_W'(timer_q) - SPAN_W'(latest_q);
    if (span[SPAN_W-1]) begin
      period_o = '0;
    end else if (|span[SPAN_W-2:RESULT_BITS]) begin
      period_o = '1;
    end else begin
      period_o = span[RESULT_BITS-1:0];
    end
  end

  // Capture first, then advance the counter and count a wrap.
  always_comb begin
    timer_d  = timer_q;
    ovf_d    = ovf_q;
    latest_d = latest_q;
    ovf_base = ovf_q;
    if (tick_i) begin
      if (edge_i) begin
        latest_d = timer_q;
        ovf_base = '0;
      end
      timer_d = timer_q + 1'b1;
      ovf_d   = ovf_base;
      if ((&timer_q) && !(&ovf_base)) begin
        ovf_d = ovf_base + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_q  <= '0;
      ovf_q    <= '0;
      latest_q <= '0;
    end else begin
      timer_q  <= timer_d;
      ovf_q    <= ovf_d;
      latest_q <= latest_d;
    end
  end

endmodule

// File: rtl/cfm_divider.sv
module cfm_divider
  import cfm_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cfm_div_req_t req_i,
  output cfm_div_sts_t sts_o
);

  logic                    busy_q, busy_d;
  logic [DIV_CNT_BITS-1:0] cnt_q, cnt_d;
  logic [DIV_BITS-1:0]     rem_q, rem_d;
  logic [DIV_BITS-1:0]     quot_q, quot_d;
  logic [DIV_BITS-1:0]     divisor_q, divisor_d;
  logic [DIV_BITS:0]       rem_shift;
  logic [DIV_BITS:0]       diff;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    rem_shift = {rem_q, quot_q[DIV_BITS-1]};
    diff      = rem_shift - {1'b0, divisor_q};
    busy_d    = busy_q;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    quot_d    = quot_q;
    divisor_d = divisor_q;
    if (req_i.start) begin
      busy_d    = 1'b1;
      cnt_d     = DIV_CNT_BITS'(DIV_BITS - 1);
      rem_d     = '0;
      quot_d    = req_i.dividend;
      divisor_d = req_i.divisor;
    end else if (busy_q) begin
      if (diff[DIV_BITS]) begin
        rem_d  = rem_shift[DIV_BITS-1:0];
        quot_d = {quot_q[DIV_BITS-2:0], 1'b0};
      end else begin
        rem_d  = diff[DIV_BITS-1:0];
        quot_d = {quot_q[DIV_BITS-2:0], 1'b1};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk_i) begin
    rem_q     <= rem_d;
    quot_q    <= quot_d;
    divisor_q <= divisor_d;
  end

  assign sts_o.busy     = busy_q;
  assign sts_o.quotient = quot_q;

endmodule

// File: rtl/capture_frequency_meter_core.sv
// Input capture period and frequency meter.
// Input channel (in_valid_i / in_stall_o): one transaction is one prescaled
// timer tick; capture_edge_i flags a rising edge on the capture pin. A tick
// without an edge is absorbed without a stall and produces no result. A tick
// with an edge captures the counter and starts the restoring divider, which
// computes tick_rate * 256 / period one quotient bit per cycle. The block
// stalls its input during that time: the divider runs its 32 steps, the
// sequencer sees it finish, the output register loads the result, and the
// next tick is taken in the cycle after the load. The stall lasts longer
// while the receiver stalls and an earlier result still sits in the output
// register.
// Output channel (out_valid_o / out_stall_i): one transaction per edge tick
// with frequency_q8_o, period_ticks_o and valid_res_o. The output register
// holds its payload while out_stall_i is high; a new tick can be accepted
// meanwhile, and a new result waits in the divider until the register frees.
// Configuration (cfg_valid_i / cfg_ready_o): writes tick_rate_hz, always ready,
// and is to be written only while the block is idle.
// Reset (rst_ni, asynchronous, active low) clears counters, captures and the
// output valid, and loads tick_rate_hz with 15625.
module capture_frequency_meter_core
  import cfm_pkg::*;
#(
  parameter int unsigned COUNTER_BITS  = 16,
  parameter int unsigned OVERFLOW_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [RATE_BITS-1:0]   cfg_tick_rate_hz_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   capture_edge_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [RESULT_BITS-1:0] frequency_q8_o,
  output logic [RESULT_BITS-1:0] period_ticks_o,
  output logic                   valid_res_o
);

  cfm_state_e              state_q, state_d;
  logic [RATE_BITS-1:0]    rate_q;
  logic [RESULT_BITS-1:0]  period_q, period_d;
  logic [RESULT_BITS-1:0]  period_now;
  logic                    in_accept;
  logic                    slot_free;
  logic                    load_out;
  logic                    out_valid_q, out_valid_d;
  logic [RESULT_BITS-1:0]  freq_q, per_q;
  logic                    vres_q;
  cfm_div_req_t            div_req;
  cfm_div_sts_t            div_sts;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign slot_free   = !out_valid_q || !out_stall_i;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= RATE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      rate_q <= cfg_tick_rate_hz_i;
    end
  end

  cfm_timer #(
    .COUNTER_BITS  (COUNTER_BITS),
    .OVERFLOW_BITS (OVERFLOW_BITS)
  ) u_timer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tick_i   (in_accept),
    .edge_i   (capture_edge_i),
    .period_o (period_now)
  );

  cfm_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .sts_o  (div_sts)
  );

  // Sequencer: start the divide on an edge tick, then hand over the result.
  always_comb begin
    state_d          = state_q;
    period_d         = period_q;
    load_out         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = {rate_q, {FRAC_BITS{1'b0}}};
    div_req.divisor  = period_now;
    case (state_q)
      ST_IDLE: begin
        if (in_accept && capture_edge_i) begin
          period_d      = period_now;
          div_req.start = 1'b1;
          state_d       = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (!div_sts.busy) begin
          state_d = ST_OUTPUT;
        end
      end
      ST_OUTPUT: begin
        if (slot_free) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers; a zero period gives no frequency.
  always_ff @(posedge clk_i) begin
    period_q <= period_d;
    if (load_out) begin
      per_q  <= period_q;
      vres_q <= (period_q != '0);
      freq_q <= (period_q != '0) ? div_sts.quotient : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign frequency_q8_o = freq_q;
  assign period_ticks_o = per_q;
  assign valid_res_o    = vres_q;

  // A valid frequency always comes with a nonzero period.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && valid_res_o |-> period_ticks_o != '0)
    else $error("valid result with zero period");

  // Without a valid frequency the frequency field reads zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !valid_res_o |-> frequency_q8_o == '0)
    else $error("nonzero frequency on invalid result");

  // The divider is never running while the sequencer is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !div_sts.busy)
    else $error("divider busy while idle");

  // An edge tick always starts a divide.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && capture_edge_i |=> state_q == ST_DIVIDE && div_sts.busy)
    else $error("edge tick did not start a divide");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb
  import cfm_pkg::*;
();

  // Narrow counters so that wraps come within a short run.
  localparam int unsigned CNT_BITS   = 8;
  localparam int unsigned OVF_BITS   = 4;
  localparam int unsigned SETTLE_CYC = 40;
  localparam int unsigned STALL_MAX  = 2000;
  localparam int unsigned ERR_SHOWN  = 10;

  // One measurement as the block reports it.
  typedef struct {
    logic [RESULT_BITS-1:0] freq_q8;
    logic [RESULT_BITS-1:0] period;
    logic                   valid;
  } meas_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [RATE_BITS-1:0] cfg_tick_rate_hz_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic capture_edge_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [RESULT_BITS-1:0] frequency_q8_o;
  logic [RESULT_BITS-1:0] period_ticks_o;
  logic valid_res_o;

  // Shadow copy of the meter state and its rate register.
  logic [RATE_BITS-1:0] shadow_rate = RATE_RESET;
  logic [CNT_BITS-1:0]  shadow_timer = '0;
  logic [OVF_BITS-1:0]  shadow_ovf = '0;
  logic [CNT_BITS-1:0]  shadow_latest = '0;
  logic [CNT_BITS-1:0]  shadow_earlier = '0;

  meas_t pending_meas[$];
  int unsigned miss_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned quiet_cycles = 0;

  capture_frequency_meter_core #(
    .COUNTER_BITS (CNT_BITS),
    .OVERFLOW_BITS(OVF_BITS)
  ) u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_tick_rate_hz_i(cfg_tick_rate_hz_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .capture_edge_i    (capture_edge_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .frequency_q8_o    (frequency_q8_o),
    .period_ticks_o    (period_ticks_o),
    .valid_res_o       (valid_res_o)
  );

  always #5 clk_i = ~clk_i;

  // Advances the shadow meter by one tick and queues the measurement it yields.
  task automatic predict_tick(input logic edge_seen);
    longint span;
    logic [63:0] quot;
    meas_t m;
    if (edge_seen) begin
      shadow_earlier = shadow_latest;
      shadow_latest  = shadow_timer;
      span = (longint'(shadow_ovf) << CNT_BITS) + longint'(shadow_latest)
             - longint'(shadow_earlier);
      if (span < 0) begin
        m.period = '0;
      end else if (span > longint'(32'hFFFF_FFFF)) begin
        m.period = '1;
      end else begin
        m.period = span[RESULT_BITS-1:0];
      end
      shadow_ovf = '0;
      quot = '0;
      if (m.period != 0) begin
        quot = (64'(shadow_rate) << FRAC_BITS) / 64'(m.period);
        if (quot > 64'hFFFF_FFFF) begin
          quot = 64'hFFFF_FFFF;
        end
      end
      m.freq_q8 = quot[RESULT_BITS-1:0];
      m.valid   = (m.period != 0);
      pending_meas.push_back(m);
    end
    shadow_timer = shadow_timer + 1'b1;
    if (shadow_timer == 0 && shadow_ovf != '1) begin
      shadow_ovf = shadow_ovf + 1'b1;
    end
  endtask

  task automatic log_miss(input string msg);
    if (miss_count < ERR_SHOWN) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    miss_count++;
  endtask

  // Sends one tick; returns right after the transaction, leaving valid high.
  task automatic send_tick(input logic edge_seen);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i     <= 1'b0;
      capture_edge_i <= 1'($urandom);
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    capture_edge_i <= edge_seen;
    do @(posedge clk_i); while (in_stall_o);
    predict_tick(edge_seen);
  endtask

  // Holds off the input until every measurement is out and the block is quiet.
  task automatic drain_block();
    in_valid_i <= 1'b0;
    while (pending_meas.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic set_rate(input logic [RATE_BITS-1:0] rate);
    drain_block();
    cfg_valid_i        <= 1'b1;
    cfg_tick_rate_hz_i <= rate;
    do @(posedge clk_i); while (!cfg_ready_o);
    shadow_rate = rate;
    cfg_valid_i <= 1'b0;
  endtask

  // The very first tick carries an edge, so the period is zero.
  task automatic test_zero_period();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_tick(1'b1);
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);
    send_tick(1'b1);
  endtask

  // Tick rates of one and 16000000, a rate with its low 23 bits set, and zero.
  task automatic test_rate_extremes();
    logic [RATE_BITS-1:0] rates[4];
    rates = '{24'd1, 24'd16000000, 24'h7F_FFFF, 24'd0};
    foreach (rates[i]) begin
      set_rate(rates[i]);
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);
    end
    set_rate(RATE_RESET);
  endtask

  // Counter wraps: a capture just before a wrap, then a span of over two wraps and one of at most a single wrap.
  task automatic test_counter_wrap();
    send_idle_pct = 0;
    recv_idle_pct = 30;
    while (shadow_timer != '1) send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    repeat (2 * (1 << CNT_BITS) + $urandom_range(31)) send_tick(1'b0);
    send_tick(1'b1);
    repeat ((1 << CNT_BITS) - 1 - $urandom_range(99)) send_tick(1'b0);
    send_tick(1'b1);
  endtask

  // Random ticks: loose edges, bursts of back-to-back edges and long gaps.
  task automatic test_random(input int unsigned s_pct, input int unsigned r_pct,
                             input int unsigned n_iter);
    int unsigned pick;
    set_rate(24'($urandom_range(16000000, 1)));
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (n_iter) begin
      pick = $urandom_range(9);
      if (pick < 6) begin
        send_tick($urandom_range(2) == 0);
      end else if (pick < 8) begin
        repeat ($urandom_range(5, 2)) send_tick(1'b1);
      end else begin
        repeat ($urandom_range(60, 10)) send_tick(1'b0);
        send_tick(1'b1);
      end
    end
  endtask

  // Result checker and receiver stall generator.
  always @(posedge clk_i) begin
    meas_t m;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_meas.size() == 0) begin
          log_miss($sformatf("unexpected result freq=%h period=%h valid=%b",
                             frequency_q8_o, period_ticks_o, valid_res_o));
        end else begin
          m = pending_meas.pop_front();
          if (frequency_q8_o !== m.freq_q8) begin
            log_miss($sformatf("frequency_q8 exp %h got %h", m.freq_q8, frequency_q8_o));
          end
          if (period_ticks_o !== m.period) begin
            log_miss($sformatf("period_ticks exp %h got %h", m.period, period_ticks_o));
          end
          if (valid_res_o !== m.valid) begin
            log_miss($sformatf("valid_res exp %b got %b", m.valid, valid_res_o));
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_MAX) begin
        $display("FAIL capture_frequency_meter_core");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_zero_period();
    test_rate_extremes();
    test_counter_wrap();
    test_random(23, 56, 30);
    test_random(56, 23, 30);
    test_random(0, 0, 30);

    // Let the last measurements come out, then watch for stray results.
    in_valid_i <= 1'b0;
    while (pending_meas.size() != 0) @(posedge clk_i);
    repeat (2 * SETTLE_CYC) @(posedge clk_i);
    if (pending_meas.size() != 0) begin
      log_miss("measurements left over at the end");
    end
    if (miss_count == 0) begin
      $display("PASS capture_frequency_meter_core");
    end else begin
      $display("FAIL capture_frequency_meter_core");
    end
    $finish;
  end

endmodule
